FILE: rtl/uer_pkg.sv
package uer_pkg;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_NEW  = 2'd2;
	localparam logic [1:0] ST_ERR  = 2'd3;

	localparam logic [1:0] PH_OFF  = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_HIGH = 2'd2;

	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DIST  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DIST  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_PULSE = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_LOW  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_HIGH = 3'd6;

	localparam int CFG_DATA_BITS = 24;
	localparam int DIST_BITS     = 24;
	localparam int TIME_BITS     = 16;

	localparam logic [DIST_BITS-1:0] DIST_MAX = 24'hFFFFFF;
	localparam logic [15:0]          MS_SAT   = 16'hFFFF;

	typedef struct packed {
		logic [15:0]          scale;
		logic [DIST_BITS-1:0] min_dist;
		logic [DIST_BITS-1:0] max_dist;
		logic [15:0]          timeout_ms;
		logic [15:0]          min_pulse;
		logic [7:0]           trig_low;
		logic [7:0]           trig_high;
	} cfg_t;

	typedef struct packed {
		logic                 start_req;
		logic                 us_tick;
		logic                 ms_tick;
		logic                 edge_valid;
		logic [TIME_BITS-1:0] edge_time;
		logic                 read_req;
	} ev_t;

	typedef struct packed {
		logic                 trig_level;
		logic [1:0]           status;
		logic                 distance_valid;
		logic [DIST_BITS-1:0] distance;
		logic [15:0]          pulse_ticks;
	} res_t;

endpackage

FILE: rtl/uer_cfg_regs.sv
module uer_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output uer_pkg::cfg_t                       cfg
);

	uer_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale      <= 16'd1;
			cfg_q.min_dist   <= 24'd512;
			cfg_q.max_dist   <= 24'd102400;
			cfg_q.timeout_ms <= 16'd60;
			cfg_q.min_pulse  <= 16'd10;
			cfg_q.trig_low   <= 8'd5;
			cfg_q.trig_high  <= 8'd20;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				uer_pkg::CFG_SCALE:     cfg_q.scale      <= cfg_data[15:0];
				uer_pkg::CFG_MIN_DIST:  cfg_q.min_dist   <= cfg_data[23:0];
				uer_pkg::CFG_MAX_DIST:  cfg_q.max_dist   <= cfg_data[23:0];
				uer_pkg::CFG_TIMEOUT:   cfg_q.timeout_ms <= cfg_data[15:0];
				uer_pkg::CFG_MIN_PULSE: cfg_q.min_pulse  <= cfg_data[15:0];
				uer_pkg::CFG_TRIG_LOW:  cfg_q.trig_low   <= cfg_data[7:0];
				uer_pkg::CFG_TRIG_HIGH: cfg_q.trig_high  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/uer_range_calc.sv
module uer_range_calc #(
	parameter int TIMESTAMP_BITS = 16
) (
	input  logic [TIMESTAMP_BITS-1:0]       width,
	input  uer_pkg::cfg_t                   cfg,
	output logic [uer_pkg::DIST_BITS-1:0]   distance,
	output logic                            in_window
);

	localparam int PW = TIMESTAMP_BITS + 16;
	localparam int DW = TIMESTAMP_BITS + 8;
	localparam int EW = (DW > uer_pkg::DIST_BITS) ? DW : uer_pkg::DIST_BITS;

	logic [PW-1:0] prod;
	logic [DW-1:0] d;
	logic [EW-1:0] d_ext;

	always_comb begin
		prod      = PW'(width) * PW'(cfg.scale);
		d         = prod[PW-1:8];
		d_ext     = EW'(d);
		distance  = (d_ext > EW'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
			: d_ext[uer_pkg::DIST_BITS-1:0];
		in_window = !((d_ext < EW'(cfg.min_dist)) || (d_ext > EW'(cfg.max_dist)));
	end

endmodule

FILE: rtl/uer_meas_core.sv
module uer_meas_core #(
	parameter int TIMESTAMP_BITS  = 16,
	parameter int TRIG_COUNT_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  uer_pkg::ev_t   ev,
	input  uer_pkg::cfg_t  cfg,
	output uer_pkg::res_t  res
);

	localparam int TS = TIMESTAMP_BITS;
	localparam int TC = TRIG_COUNT_BITS;
	localparam int WW = (TS > 16) ? TS : 16;

	logic [1:0]                      status_q, status_d;
	logic [TS-1:0]                   first_q, first_d;
	logic [1:0]                      edges_q, edges_d;
	logic [15:0]                     pulse_q, pulse_d;
	logic [uer_pkg::DIST_BITS-1:0]   dist_q, dist_d;
	logic [15:0]                     elapsed_q, elapsed_d;
	logic [1:0]                      phase_q, phase_d;
	logic [TC-1:0]                   tcount_q, tcount_d;

	logic [TS-1:0]                   et;
	logic [TS-1:0]                   width;
	logic [uer_pkg::DIST_BITS-1:0]   calc_dist;
	logic                            calc_ok;
	logic                            took;

	assign et    = TS'(ev.edge_time);
	assign width = TS'(et - first_q);

	uer_range_calc #(
		.TIMESTAMP_BITS(TS)
	) u_range (
		.width    (width),
		.cfg      (cfg),
		.distance (calc_dist),
		.in_window(calc_ok)
	);

	always_comb begin
		status_d  = status_q;
		first_d   = first_q;
		edges_d   = edges_q;
		pulse_d   = pulse_q;
		dist_d    = dist_q;
		elapsed_d = elapsed_q;
		phase_d   = phase_q;
		tcount_d  = tcount_q;
		took      = 1'b0;

		if (ev.start_req && (status_q != uer_pkg::ST_BUSY)) begin
			status_d  = uer_pkg::ST_BUSY;
			pulse_d   = '0;
			edges_d   = 2'd0;
			elapsed_d = '0;
			phase_d   = uer_pkg::PH_LOW;
			tcount_d  = TC'(cfg.trig_low);
		end else if ((phase_q == uer_pkg::PH_LOW) || (phase_q == uer_pkg::PH_HIGH)) begin
			if ((tcount_q == '0) || (ev.us_tick && (tcount_q == TC'(1)))) begin
				if (phase_q == uer_pkg::PH_LOW) begin
					phase_d  = uer_pkg::PH_HIGH;
					tcount_d = TC'(cfg.trig_high);
				end else begin
					phase_d  = uer_pkg::PH_OFF;
					tcount_d = '0;
				end
			end else if (ev.us_tick) begin
				tcount_d = tcount_q - TC'(1);
			end
		end

		if (ev.edge_valid && (status_d == uer_pkg::ST_BUSY)) begin
			if (edges_d == 2'd0) begin
				first_d = et;
				edges_d = 2'd1;
			end else if (edges_d == 2'd1) begin
				edges_d = 2'd2;
				if (WW'(width) >= WW'(cfg.min_pulse)) begin
					pulse_d  = 16'(width);
					dist_d   = calc_dist;
					status_d = calc_ok ? uer_pkg::ST_NEW : uer_pkg::ST_ERR;
				end
			end
		end

		if (status_d == uer_pkg::ST_BUSY) begin
			if (ev.ms_tick && (elapsed_d != uer_pkg::MS_SAT))
				elapsed_d = elapsed_d + 16'd1;
			if (elapsed_d >= cfg.timeout_ms)
				status_d = uer_pkg::ST_ERR;
		end

		if (ev.read_req && (status_d == uer_pkg::ST_NEW)) begin
			took     = 1'b1;
			status_d = uer_pkg::ST_IDLE;
		end

		res.trig_level     = (phase_d == uer_pkg::PH_HIGH);
		res.status         = status_d;
		res.distance_valid = took;
		res.distance       = dist_d;
		res.pulse_ticks    = pulse_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= uer_pkg::ST_IDLE;
			first_q   <= '0;
			edges_q   <= 2'd0;
			pulse_q   <= '0;
			dist_q    <= '0;
			elapsed_q <= '0;
			phase_q   <= uer_pkg::PH_OFF;
			tcount_q  <= '0;
		end else if (go) begin
			status_q  <= status_d;
			first_q   <= first_d;
			edges_q   <= edges_d;
			pulse_q   <= pulse_d;
			dist_q    <= dist_d;
			elapsed_q <= elapsed_d;
			phase_q   <= phase_d;
			tcount_q  <= tcount_d;
		end
	end

endmodule

FILE: rtl/ultrasonic_echo_ranger_core.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   start_req us_tick ms_tick edge_valid
//                                            edge_time read_req
// out       output     out_valid / out_stall trig_level status distance_valid
//                                            distance pulse_ticks
// cfg       input      cfg_valid / cfg_ready cfg_index cfg_data
//
// One request per cycle sustained while out_stall is low; each result passes through the
// input register, then the result register. The measurement state updates from the
// registered request, with one multiply and the window compares.
// arst_n clears all measurement state and loads the register defaults.
// A stalled result holds; one further request is still taken into the input register.
module ultrasonic_echo_ranger_core #(
	parameter int TIMESTAMP_BITS  = 16,
	parameter int TRIG_COUNT_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                start_req,
	input  logic                                us_tick,
	input  logic                                ms_tick,
	input  logic                                edge_valid,
	input  logic [uer_pkg::TIME_BITS-1:0]       edge_time,
	input  logic                                read_req,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                trig_level,
	output logic [1:0]                          status,
	output logic                                distance_valid,
	output logic [uer_pkg::DIST_BITS-1:0]       distance,
	output logic [15:0]                         pulse_ticks,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	uer_pkg::cfg_t cfg;
	uer_pkg::ev_t  ev_s1;
	uer_pkg::res_t res_next;
	uer_pkg::res_t res_q;
	logic          valid_s1;
	logic          out_valid_q;
	logic          s1_go;
	logic          in_take;

	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;

	uer_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	uer_meas_core #(
		.TIMESTAMP_BITS (TIMESTAMP_BITS),
		.TRIG_COUNT_BITS(TRIG_COUNT_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (s1_go),
		.ev    (ev_s1),
		.cfg   (cfg),
		.res   (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ev_s1.start_req  <= start_req;
			ev_s1.us_tick    <= us_tick;
			ev_s1.ms_tick    <= ms_tick;
			ev_s1.edge_valid <= edge_valid;
			ev_s1.edge_time  <= edge_time;
			ev_s1.read_req   <= read_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			res_q <= res_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign trig_level     = res_q.trig_level;
	assign status         = res_q.status;
	assign distance_valid = res_q.distance_valid;
	assign distance       = res_q.distance;
	assign pulse_ticks    = res_q.pulse_ticks;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(ev_s1))
		else $error("held request lost or changed");

	a_go_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> out_valid_q)
		else $error("processed request gave no result");

	a_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.distance_valid |-> res_q.status == uer_pkg::ST_IDLE)
		else $error("distance taken without return to idle");

endmodule

FILE: tb/sv/ultrasonic_echo_ranger_core_tb.sv
module ultrasonic_echo_ranger_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uer_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 190;

	localparam cfg_t RESET_REGS = '{16'd1, 24'd512, 24'd102400, 16'd60, 16'd10, 8'd5, 8'd20};

	typedef struct {
		bit   is_cfg;
		cfg_t regs;
		ev_t  ev;
		bit   typed;
		res_t fixed;
	} plan_row_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     start_req      = 1'b0;
	logic                     us_tick        = 1'b0;
	logic                     ms_tick        = 1'b0;
	logic                     edge_valid     = 1'b0;
	logic [TIME_BITS-1:0]     edge_time      = '0;
	logic                     read_req       = 1'b0;
	logic                     out_stall      = 1'b0;
	logic                     cfg_valid      = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index      = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data       = '0;
	logic                     in_stall;
	logic                     out_valid;
	logic                     trig_level;
	logic [1:0]               status;
	logic                     distance_valid;
	logic [DIST_BITS-1:0]     distance;
	logic [15:0]              pulse_ticks;
	logic                     cfg_ready;

	ultrasonic_echo_ranger_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.start_req      (start_req),
		.us_tick        (us_tick),
		.ms_tick        (ms_tick),
		.edge_valid     (edge_valid),
		.edge_time      (edge_time),
		.read_req       (read_req),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.trig_level     (trig_level),
		.status         (status),
		.distance_valid (distance_valid),
		.distance       (distance),
		.pulse_ticks    (pulse_ticks),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state and register copy
	cfg_t        regs       = RESET_REGS;
	logic [1:0]  meas_state = ST_IDLE;
	logic [15:0] first_edge = '0;
	logic [1:0]  edge_count = '0;
	logic [15:0] held_pulse = '0;
	logic [23:0] held_range = '0;
	logic [15:0] ms_count   = '0;
	logic [1:0]  pin_phase  = PH_OFF;
	logic [7:0]  trig_left  = '0;

	res_t        pending_readouts[$];
	int          mismatches  = 0;
	int          cycle_count = 0;
	int          items_sent  = 0;
	int          gap_rate    = 0;
	int          stall_rate  = 0;
	int          stall_left  = 0;

	function automatic res_t ranger_next(input ev_t ev);
		res_t        r;
		logic [15:0] width;
		logic [31:0] product;
		logic [23:0] range_cm;
		bit          taken;
		taken = 1'b0;
		if (ev.start_req && meas_state != ST_BUSY) begin
			meas_state = ST_BUSY;
			held_pulse = '0;
			edge_count = '0;
			ms_count   = '0;
			pin_phase  = PH_LOW;
			trig_left  = regs.trig_low;
		end else if (pin_phase == PH_LOW || pin_phase == PH_HIGH) begin
			if (trig_left == 8'd0 || (ev.us_tick && trig_left == 8'd1)) begin
				if (pin_phase == PH_LOW) begin
					pin_phase = PH_HIGH;
					trig_left = regs.trig_high;
				end else begin
					pin_phase = PH_OFF;
					trig_left = 8'd0;
				end
			end else if (ev.us_tick) begin
				trig_left = trig_left - 8'd1;
			end
		end
		if (ev.edge_valid && meas_state == ST_BUSY) begin
			if (edge_count == 2'd0) begin
				first_edge = ev.edge_time;
				edge_count = 2'd1;
			end else if (edge_count == 2'd1) begin
				width      = ev.edge_time - first_edge;
				edge_count = 2'd2;
				if (width >= regs.min_pulse) begin
					held_pulse = width;
					product    = width * regs.scale;
					range_cm   = product[31:8];
					held_range = range_cm;
					if (range_cm < regs.min_dist || range_cm > regs.max_dist) begin
						meas_state = ST_ERR;
					end else begin
						meas_state = ST_NEW;
					end
				end
			end
		end
		if (meas_state == ST_BUSY) begin
			if (ev.ms_tick && ms_count != MS_SAT) begin
				ms_count = ms_count + 16'd1;
			end
			if (ms_count >= regs.timeout_ms) begin
				meas_state = ST_ERR;
			end
		end
		if (ev.read_req && meas_state == ST_NEW) begin
			taken      = 1'b1;
			meas_state = ST_IDLE;
		end
		r.trig_level     = (pin_phase == PH_HIGH);
		r.status         = meas_state;
		r.distance_valid = taken;
		r.distance       = held_range;
		r.pulse_ticks    = held_pulse;
		return r;
	endfunction

	function automatic plan_row_t item_row(input ev_t ev, input bit typed, input res_t fixed);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.regs   = RESET_REGS;
		row.ev     = ev;
		row.typed  = typed;
		row.fixed  = fixed;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input cfg_t s);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.regs   = s;
		row.ev     = '0;
		row.typed  = 1'b0;
		row.fixed  = '0;
		return row;
	endfunction

	function automatic ev_t tick_ev();
		ev_t ev;
		ev.start_req  = 1'b0;
		ev.us_tick    = 1'($urandom);
		ev.ms_tick    = ($urandom_range(0, 11) == 0);
		ev.edge_valid = 1'b0;
		ev.edge_time  = 16'($urandom);
		ev.read_req   = ($urandom_range(0, 9) == 0);
		return ev;
	endfunction

	function automatic ev_t noise_ev();
		ev_t ev;
		ev.start_req  = ($urandom_range(0, 7) == 0);
		ev.us_tick    = 1'($urandom);
		ev.ms_tick    = ($urandom_range(0, 3) == 0);
		ev.edge_valid = ($urandom_range(0, 2) == 0);
		ev.edge_time  = 16'($urandom);
		ev.read_req   = ($urandom_range(0, 3) == 0);
		return ev;
	endfunction

	function automatic logic [15:0] pick_width();
		longint unsigned aim;
		case ($urandom_range(0, 7))
			0: return regs.min_pulse - 16'd1;
			1: return regs.min_pulse;
			2: return 16'hFFFF;
			3, 4, 5: begin
				if (regs.scale != 16'd0 && regs.min_dist <= regs.max_dist) begin
					aim = $urandom_range(regs.min_dist, regs.max_dist);
					aim = ((aim << 8) + regs.scale - 1) / regs.scale;
					if (aim <= 64'hFFFF) begin
						return 16'(aim);
					end
				end
			end
			default: ;
		endcase
		return 16'($urandom);
	endfunction

	function automatic cfg_t random_settings();
		cfg_t        s;
		logic [23:0] swap;
		s.scale      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(64, 4096));
		s.min_dist   = 24'($urandom_range(0, 4096));
		s.max_dist   = 24'($urandom_range(s.min_dist, 24'hFFFFFF));
		if ($urandom_range(0, 7) == 0) begin
			swap       = s.min_dist;
			s.min_dist = s.max_dist;
			s.max_dist = swap;
		end
		s.timeout_ms = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 6));
		s.min_pulse  = 16'($urandom_range(0, 200));
		s.trig_low   = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
		s.trig_high  = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
		return s;
	endfunction

	task automatic push_event(input ev_t ev, input bit typed, input res_t fixed);
		res_t predicted;
		in_valid <= 1'b1;
		{start_req, us_tick, ms_tick, edge_valid, edge_time, read_req} <= ev;
		do @(posedge clk); while (in_stall);
		predicted = ranger_next(ev);
		pending_readouts.push_back(typed ? fixed : predicted);
		items_sent++;
		if (gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input cfg_t s);
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(CFG_SCALE, 24'(s.scale));
		write_reg(CFG_MIN_DIST, s.min_dist);
		write_reg(CFG_MAX_DIST, s.max_dist);
		write_reg(CFG_TIMEOUT, 24'(s.timeout_ms));
		write_reg(CFG_MIN_PULSE, 24'(s.min_pulse));
		write_reg(CFG_TRIG_LOW, 24'(s.trig_low));
		write_reg(CFG_TRIG_HIGH, 24'(s.trig_high));
		cfg_valid <= 1'b0;
		regs = s;
	endtask

	task automatic run_measurement();
		ev_t         ev;
		logic [15:0] t0;
		t0 = 16'($urandom);
		ev = tick_ev();
		ev.start_req = 1'b1;
		push_event(ev, 1'b0, '0);
		repeat ($urandom_range(0, 6)) push_event(tick_ev(), 1'b0, '0);
		ev = tick_ev();
		ev.edge_valid = 1'b1;
		ev.edge_time  = t0;
		push_event(ev, 1'b0, '0);
		repeat ($urandom_range(0, 4)) push_event(tick_ev(), 1'b0, '0);
		ev = tick_ev();
		ev.edge_valid = 1'b1;
		ev.edge_time  = t0 + pick_width();
		push_event(ev, 1'b0, '0);
		repeat ($urandom_range(0, 3)) begin
			ev = tick_ev();
			ev.edge_valid = 1'($urandom);
			push_event(ev, 1'b0, '0);
		end
		ev = tick_ev();
		ev.read_req = 1'b1;
		push_event(ev, 1'b0, '0);
	endtask

	task automatic compare_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readouts.size() == 0) begin
				$display("%0t ns: result with nothing expected, status 0x%0h distance 0x%0h",
					$time, status, distance);
				mismatches++;
			end else begin
				want = pending_readouts.pop_front();
				compare_field("trig_level", want.trig_level, trig_level);
				compare_field("status", want.status, status);
				compare_field("distance_valid", want.distance_valid, distance_valid);
				compare_field("distance", want.distance, distance);
				compare_field("pulse_ticks", want.pulse_ticks, pulse_ticks);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || stall_rate == 0) begin
			stall_left <= 0;
			out_stall  <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if ($urandom_range(0, stall_rate) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		plan_row_t directed_plan[$];
		int        phase_start;
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1}, 1'b1,
			'{1'b0, ST_IDLE, 1'b0, 24'h0, 16'h0}));
		directed_plan.push_back(item_row('{1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b0}, 1'b1,
			'{1'b0, ST_IDLE, 1'b0, 24'h0, 16'h0}));
		directed_plan.push_back(item_row('{1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b1,
			'{1'b0, ST_BUSY, 1'b0, 24'h0, 16'h0}));
		directed_plan.push_back(item_row('{1'b1, 1'b0, 1'b0, 1'b1, 16'hFFF0, 1'b0}, 1'b1,
			'{1'b0, ST_BUSY, 1'b0, 24'h0, 16'h0}));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b0, 1'b1, 16'h0005, 1'b0}, 1'b1,
			'{1'b0, ST_ERR, 1'b0, 24'h0, 16'd21}));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1}, 1'b1,
			'{1'b0, ST_ERR, 1'b0, 24'h0, 16'd21}));
		directed_plan.push_back(item_row('{1'b1, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0}, 1'b1,
			'{1'b0, ST_BUSY, 1'b0, 24'h0, 16'h0}));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b0, 1'b1, 16'h0005, 1'b0}, 1'b1,
			'{1'b0, ST_BUSY, 1'b0, 24'h0, 16'h0}));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b0, 1'b1, 16'h8000, 1'b1}, 1'b1,
			'{1'b0, ST_BUSY, 1'b0, 24'h0, 16'h0}));
		repeat (5) directed_plan.push_back(item_row('{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
			1'b0, '0));
		directed_plan.push_back(cfg_row('{16'hFFFF, 24'h0, 24'hFFFFFF, 16'd2, 16'd0, 8'd0, 8'd0}));
		repeat (2) directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
			1'b0, '0));
		directed_plan.push_back(item_row('{1'b1, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b0}, 1'b0, '0));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0}, 1'b1,
			'{1'b1, ST_NEW, 1'b0, 24'hFFFE00, 16'hFFFF}));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1}, 1'b1,
			'{1'b0, ST_IDLE, 1'b1, 24'hFFFE00, 16'hFFFF}));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1}, 1'b1,
			'{1'b0, ST_IDLE, 1'b0, 24'hFFFE00, 16'hFFFF}));
		directed_plan.push_back(item_row('{1'b1, 1'b0, 1'b0, 1'b1, 16'h000A, 1'b0}, 1'b0, '0));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0}, 1'b0, '0));
		directed_plan.push_back(item_row('{1'b0, 1'b0, 1'b1, 1'b1, 16'h0014, 1'b0}, 1'b0, '0));
		directed_plan.push_back(item_row('{1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1}, 1'b0, '0));
		directed_plan.push_back(cfg_row('{16'h0100, 24'h80, 24'h100, 16'd0, 16'd0, 8'd1, 8'd1}));
		directed_plan.push_back(item_row('{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0));
		directed_plan.push_back(item_row('{1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0}, 1'b0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_rate   = 3;
		stall_rate = 3;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg) begin
				load_settings(directed_plan[i].regs);
			end else begin
				push_event(directed_plan[i].ev, directed_plan[i].typed, directed_plan[i].fixed);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				gap_rate   = 0;
				stall_rate = 0;
			end else begin
				gap_rate   = 3 * $urandom_range(0, 2);
				stall_rate = 3 * $urandom_range(0, 2);
			end
			case (p)
				0: load_settings('{16'h0000, 24'h0, 24'h0, 16'd2, 16'd0, 8'hFF, 8'hFF});
				1: load_settings('{16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd1, 16'd0, 8'd0, 8'd0});
				2: load_settings('{16'd300, 24'd0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'd2, 8'd3});
				default: load_settings(random_settings());
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) != 0) begin
					run_measurement();
				end else begin
					repeat ($urandom_range(1, 5)) push_event(noise_ev(), 1'b0, '0);
				end
			end
		end

		if (in_valid) begin
			in_valid <= 1'b0;
		end
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_readouts.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
